/* rtl/sau_pkg.sv */
// ----------------------------------------------------------------------------
// sau_pkg: shared types and constants of the stack arithmetic unit
// Word and stack sizes, command and status codes, controller states and the
// control word that steers each stack cell.
// ----------------------------------------------------------------------------
package sau_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int WORD_WIDTH  = 32;
    localparam int COUNT_W     = 7;
    localparam int CMD_W       = 3;
    localparam int DIV_CNT_W   = $clog2(WORD_WIDTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_DIV  = 3'd3,
        CMD_MUL  = 3'd4,
        CMD_MOD  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIVIDE,
        S_COMMIT
    } state_t;

    // en: load a new word this cycle; up: take the word from the cell below
    // (pop) instead of the one above (push)
    typedef struct packed {
        logic en;
        logic up;
    } cell_ctrl_t;

endpackage

/* rtl/sau_cell.sv */
// ----------------------------------------------------------------------------
// sau_cell: one entry of the shifting operand stack
// Holds one word and, when enabled, takes the word of its upper neighbor
// (push) or of its lower neighbor (pop).
// ----------------------------------------------------------------------------
module sau_cell
    import sau_pkg::*;
(
    input  logic                  aclk,
    input  cell_ctrl_t            ctrl,
    input  logic [WORD_WIDTH-1:0] prev_word,
    input  logic [WORD_WIDTH-1:0] next_word,
    output logic [WORD_WIDTH-1:0] word
);

    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;

    // select the neighbor word, or hold
    always_comb begin
        if (!ctrl.en) begin
            word_next = word_reg;
        end else if (ctrl.up) begin
            word_next = next_word;
        end else begin
            word_next = prev_word;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

/* rtl/sau_divider.sv */
// ----------------------------------------------------------------------------
// sau_divider: iterative signed divider, one quotient bit per cycle
// Restoring division on magnitudes; quotient truncates toward zero and the
// remainder takes the sign of the dividend.
// ----------------------------------------------------------------------------
module sau_divider
    import sau_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic                  is_mod,
    input  logic [WORD_WIDTH-1:0] dividend,
    input  logic [WORD_WIDTH-1:0] divisor,
    output logic                  done,
    output logic [WORD_WIDTH-1:0] result
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_WIDTH-1:0] rem_reg, rem_next;
    logic [WORD_WIDTH-1:0] quo_reg, quo_next;
    logic [WORD_WIDTH-1:0] dsr_reg, dsr_next;
    logic                  mod_reg, mod_next;
    logic                  neg_q_reg, neg_q_next;
    logic                  neg_r_reg, neg_r_next;

    logic [WORD_WIDTH:0]   shifted;
    logic [WORD_WIDTH:0]   diff;
    logic [WORD_WIDTH-1:0] mag_a;
    logic [WORD_WIDTH-1:0] mag_b;

    // operand magnitudes
    assign mag_a = dividend[WORD_WIDTH-1] ? (~dividend + 1'b1) : dividend;
    assign mag_b = divisor[WORD_WIDTH-1]  ? (~divisor + 1'b1)  : divisor;

    // one restoring step
    assign shifted = {rem_reg, quo_reg[WORD_WIDTH-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        mod_next   = mod_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = DIV_CNT_W'(WORD_WIDTH - 1);
            rem_next   = '0;
            quo_next   = mag_a;
            dsr_next   = mag_b;
            mod_next   = is_mod;
            neg_q_next = dividend[WORD_WIDTH-1] ^ divisor[WORD_WIDTH-1];
            neg_r_next = dividend[WORD_WIDTH-1];
        end else if (busy_reg) begin
            if (!diff[WORD_WIDTH]) begin
                rem_next = diff[WORD_WIDTH-1:0];
                quo_next = {quo_reg[WORD_WIDTH-2:0], 1'b1};
            end else begin
                rem_next = shifted[WORD_WIDTH-1:0];
                quo_next = {quo_reg[WORD_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dsr_reg   <= dsr_next;
        mod_reg   <= mod_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    // apply signs to the finished magnitudes
    always_comb begin
        if (mod_reg) begin
            result = neg_r_reg ? (~rem_reg + 1'b1) : rem_reg;
        end else begin
            result = neg_q_reg ? (~quo_reg + 1'b1) : quo_reg;
        end
    end

    assign done = done_reg;

endmodule

/* rtl/stack_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// stack_arithmetic_unit: operand stack with push, add, sub, mul, div and mod
// The stack is a row of shifting cells, top entry in cell 0.
//
// Usage: one command word enters on the s_ channel (s_tuser = command,
// s_tdata = push value) and each command returns exactly one result word
// on the m_ channel (m_tuser = status, m_tdata = new top and entry count).
// Arithmetic combines second entry op top, pops, and leaves the result on
// top; errors (short stack, zero divisor, full stack) leave the stack as it
// was and report the current top and count.
// Flow: each command is held in the command register and worked in the
// execute state; its result is then registered in the output register,
// and no new command is taken before that commit. Div and mod run through
// the bit-serial divider, one quotient bit per cycle, before they commit.
// Reset empties the stack (entry count zero) and clears the output channel.
// When the receiver stalls, the finished result holds in the output
// register; the next command is still accepted and worked on, and its
// update waits until the output register is free.
// ----------------------------------------------------------------------------
module stack_arithmetic_unit
    import sau_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [2:0]  s_tuser,   // [2:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] top_value, [38:32] entry_count, [39] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    state_t state_reg, state_next;

    logic [CMD_W-1:0]      cmd_reg;
    logic [WORD_WIDTH-1:0] val_reg;
    logic [COUNT_W-1:0]    count_reg, count_next;

    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic [WORD_WIDTH-1:0] out_top_reg, out_top_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;

    logic [WORD_WIDTH-1:0] cell_word [STACK_DEPTH];
    logic [WORD_WIDTH-1:0] top_word;
    logic [WORD_WIDTH-1:0] second_word;
    logic [WORD_WIDTH-1:0] head_word;
    logic [WORD_WIDTH-1:0] arith_word;
    logic [WORD_WIDTH-1:0] prod_word;
    logic [WORD_WIDTH-1:0] div_result;
    logic                  div_done;
    logic                  div_start;

    logic       accept;
    logic       out_free;
    logic       commit;
    logic       is_arith;
    logic       is_divmod;
    logic       short_err;
    logic       divz_err;
    logic       full_err;
    logic       do_push;
    logic       do_pop;
    logic       div_ok;
    status_t    status_now;
    cell_ctrl_t head_ctrl;
    cell_ctrl_t body_ctrl;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign top_word    = cell_word[0];
    assign second_word = cell_word[1];

    // decode the held command against the current stack
    assign is_arith  = (cmd_reg == CMD_ADD) || (cmd_reg == CMD_SUB) ||
                       (cmd_reg == CMD_MUL) || (cmd_reg == CMD_DIV) ||
                       (cmd_reg == CMD_MOD);
    assign is_divmod = (cmd_reg == CMD_DIV) || (cmd_reg == CMD_MOD);
    assign short_err = is_arith && (count_reg < COUNT_W'(2));
    assign divz_err  = is_divmod && !short_err && (top_word == '0);
    assign full_err  = (cmd_reg == CMD_PUSH) && (count_reg >= COUNT_W'(STACK_DEPTH));
    assign do_push   = (cmd_reg == CMD_PUSH) && !full_err;
    assign do_pop    = is_arith && !short_err && !divz_err;
    assign div_ok    = is_divmod && !short_err && !divz_err;

    always_comb begin
        if (short_err) begin
            status_now = ST_SHORT;
        end else if (divz_err) begin
            status_now = ST_DIVZERO;
        end else if (full_err) begin
            status_now = ST_FULL;
        end else begin
            status_now = ST_OK;
        end
    end

    // combinational add, sub and mul, second op top
    assign prod_word = second_word * top_word;

    always_comb begin
        case (cmd_reg)
            CMD_ADD: arith_word = second_word + top_word;
            CMD_SUB: arith_word = second_word - top_word;
            CMD_MUL: arith_word = prod_word;
            default: arith_word = div_result;
        endcase
    end

    assign head_word = do_push ? val_reg : arith_word;

    // controller: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (div_ok) begin
                    state_next = S_DIVIDE;
                end else if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_DIVIDE: begin
                if (div_done) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // controller: outputs
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        commit    = 1'b0;
        case (state_reg)
            S_IDLE: s_tready = 1'b1;
            S_EXEC: begin
                div_start = div_ok;
                commit    = !div_ok && out_free;
            end
            S_COMMIT: commit = out_free;
            default: ;
        endcase
    end

    // steer the cells: push shifts down, pop shifts up under a new head
    assign head_ctrl.en = commit && (do_push || do_pop);
    assign head_ctrl.up = 1'b0;
    assign body_ctrl.en = commit && (do_push || do_pop);
    assign body_ctrl.up = do_pop;

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic [WORD_WIDTH-1:0] prev_w;
        logic [WORD_WIDTH-1:0] next_w;
        if (i == 0) begin : g_head
            assign prev_w = head_word;
        end else begin : g_body
            assign prev_w = cell_word[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_last
            assign next_w = '0;
        end else begin : g_inner
            assign next_w = cell_word[i+1];
        end
        sau_cell u_cell (
            .aclk      (aclk),
            .ctrl      ((i == 0) ? head_ctrl : body_ctrl),
            .prev_word (prev_w),
            .next_word (next_w),
            .word      (cell_word[i])
        );
    end

    sau_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .is_mod   (cmd_reg == CMD_MOD),
        .dividend (second_word),
        .divisor  (top_word),
        .done     (div_done),
        .result   (div_result)
    );

    // stack count and result word
    always_comb begin
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_top_next    = out_top_reg;
        out_count_next  = out_count_reg;
        if (commit) begin
            out_valid_next  = 1'b1;
            out_status_next = status_now;
            if (do_push) begin
                count_next     = count_reg + 1'b1;
                out_top_next   = val_reg;
                out_count_next = count_reg + 1'b1;
            end else if (do_pop) begin
                count_next     = count_reg - 1'b1;
                out_top_next   = arith_word;
                out_count_next = count_reg - 1'b1;
            end else begin
                out_top_next   = (count_reg == '0) ? '0 : top_word;
                out_count_next = count_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_tuser;
            val_reg <= s_tdata;
        end
        out_status_reg <= out_status_next;
        out_top_reg    <= out_top_next;
        out_count_reg  <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_top_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[38:32] == COUNT_W'(STACK_DEPTH)))
        else $error("full status without a full stack");

    a_short_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_SHORT) |-> (m_tdata[38:32] < COUNT_W'(2)))
        else $error("short status with two or more entries");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIVIDE))
        else $error("divider finished outside the divide state");
`endif

endmodule

/* tb/sv/stack_arithmetic_unit_tb.sv */
// ----------------------------------------------------------------------------
// stack_arithmetic_unit_tb: self-checking bench for the stack arithmetic unit
// Builds a command plan up front, a short directed table followed by
// randomized stack programs, and works out unpinned results with a local
// stack model as the plan is built. Both stream sides idle at random, and the
// receiver holds off once for a long stretch. Results are checked in order.
// ----------------------------------------------------------------------------
module stack_arithmetic_unit_tb;
    import sau_pkg::*;

    typedef logic signed [WORD_WIDTH-1:0] word_t;
    typedef logic [WORD_WIDTH-1:0]        mag_t;

    typedef struct packed {
        status_t            status;
        word_t              top;
        logic [COUNT_W-1:0] count;
    } sau_result_t;

    // pinned rows carry a hand-written result; the rest take the model's
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        word_t            value;
        logic             pinned;
        sau_result_t      result;
    } command_row_t;

    // command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam word_t WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
    localparam word_t WORD_ONE = 1;
    localparam word_t WORD_NEG = -1;

    localparam int DIRECTED_ROWS  = 26;
    localparam int RANDOM_ITEMS   = 450;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 80;
    localparam int IDLE_PERCENT   = 11;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [31:0] push_value
    logic [2:0]  s_tuser;    // [2:0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // [31:0] top_value, [38:32] entry_count, [39] zero
    logic [1:0]  m_tuser;    // [1:0] status

    // model stack, entry 0 at the bottom
    word_t stack_cells [STACK_DEPTH];
    int    stack_depth;

    command_row_t directed_table [DIRECTED_ROWS];
    command_row_t command_plan_q [$];
    sau_result_t  pending_results_q [$];

    int arith_planned;
    int words_accepted = 0;
    int results_seen = 0;
    int error_count = 0;

    stack_arithmetic_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Apply one command to the model stack and return the result word
    function automatic sau_result_t stack_execute(input logic [CMD_W-1:0] cmd,
                                                  input word_t value);
        sau_result_t r;
        word_t       a;
        word_t       b;
        word_t       res;
        mag_t        ma;
        mag_t        mb;
        mag_t        q;
        logic        na;
        logic        nb;
        logic        ok;
        r.status = ST_OK;
        res = '0;
        ok = 1'b1;
        case (cmd)
            CMD_PUSH: begin
                if (stack_depth >= STACK_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stack_cells[stack_depth] = value;
                    stack_depth++;
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
                if (stack_depth < 2) begin
                    r.status = ST_SHORT;
                end else begin
                    a = stack_cells[stack_depth-2];
                    b = stack_cells[stack_depth-1];
                    na = a[WORD_WIDTH-1];
                    nb = b[WORD_WIDTH-1];
                    ma = na ? mag_t'(-a) : mag_t'(a);
                    mb = nb ? mag_t'(-b) : mag_t'(b);
                    if (cmd == CMD_ADD) begin
                        res = a + b;
                    end else if (cmd == CMD_SUB) begin
                        res = a - b;
                    end else if (cmd == CMD_MUL) begin
                        res = a * b;
                    end else if (b == 0) begin
                        r.status = ST_DIVZERO;
                        ok = 1'b0;
                    end else if (cmd == CMD_DIV) begin
                        // truncate toward zero on magnitudes, then sign
                        q = ma / mb;
                        res = (na ^ nb) ? word_t'(-q) : word_t'(q);
                    end else begin
                        // remainder follows the dividend's sign
                        q = ma % mb;
                        res = na ? word_t'(-q) : word_t'(q);
                    end
                    if (ok) begin
                        stack_cells[stack_depth-2] = res;
                        stack_depth--;
                    end
                end
            end
            default: ;
        endcase
        r.top = (stack_depth == 0) ? '0 : stack_cells[stack_depth-1];
        r.count = stack_depth[COUNT_W-1:0];
        return r;
    endfunction

    // Append a command to the plan with its predicted result
    task automatic plan_command(input logic [CMD_W-1:0] cmd, input word_t value);
        command_row_t row;
        row.cmd = cmd;
        row.value = value;
        row.pinned = 1'b0;
        row.result = stack_execute(cmd, value);
        if (cmd <= CMD_MOD)
            arith_planned++;
        command_plan_q.push_back(row);
    endtask

    // Operand values, weighted toward the corner cases
    function automatic word_t pick_word();
        word_t w;
        case ($urandom_range(0, 9))
            0: w = '0;
            1: w = WORD_NEG;
            2: w = WORD_MIN;
            3: w = WORD_MAX;
            4: w = WORD_ONE;
            5, 6: w = word_t'($urandom_range(0, 40)) - 20;
            default: w = word_t'($urandom);
        endcase
        return w;
    endfunction

    function automatic logic [CMD_W-1:0] pick_arith();
        logic [CMD_W-1:0] c;
        case ($urandom_range(0, 4))
            0: c = CMD_ADD;
            1: c = CMD_SUB;
            2: c = CMD_MUL;
            3: c = CMD_DIV;
            default: c = CMD_MOD;
        endcase
        return c;
    endfunction

    // Build the full command plan: directed table, then random programs
    task automatic build_plan();
        command_row_t row;
        sau_result_t  predicted;
        int           len;
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = directed_table[i];
            predicted = stack_execute(row.cmd, row.value);
            if (!row.pinned)
                row.result = predicted;
            command_plan_q.push_back(row);
        end
        arith_planned = 0;
        while (arith_planned < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    // fill to the top, push into the full stack, then drain
                    while (stack_depth < STACK_DEPTH)
                        plan_command(CMD_PUSH, word_t'($urandom));
                    repeat ($urandom_range(1, 3)) plan_command(CMD_PUSH, pick_word());
                    repeat ($urandom_range(5, 70)) plan_command(pick_arith(), word_t'($urandom));
                end
                1: begin
                    // noise: any code, any value
                    repeat ($urandom_range(3, 8))
                        plan_command(CMD_W'($urandom_range(0, 7)), word_t'($urandom));
                end
                2: begin
                    // drain down to one entry and run the stack short
                    while (stack_depth > 1)
                        plan_command(pick_arith(), word_t'($urandom));
                    repeat ($urandom_range(1, 3)) plan_command(pick_arith(), word_t'($urandom));
                end
                default: begin
                    // well-formed expression with random operands
                    len = $urandom_range(4, 16);
                    repeat (len) begin
                        if (stack_depth < 2 ||
                            (stack_depth < STACK_DEPTH - 4 && $urandom_range(0, 99) < 45))
                            plan_command(CMD_PUSH, pick_word());
                        else
                            plan_command(pick_arith(), word_t'($urandom));
                    end
                end
            endcase
        end
    endtask

    // Reset, plan and stimulus
    initial begin
        directed_table = '{
            '{CMD_ADD,     '0,       1'b1, '{ST_SHORT,   '0,       7'd0}},
            '{CMD_DIV,     '0,       1'b1, '{ST_SHORT,   '0,       7'd0}},
            '{CMD_SPARE_6, WORD_NEG, 1'b1, '{ST_OK,      '0,       7'd0}},
            '{CMD_PUSH,    WORD_MAX, 1'b1, '{ST_OK,      WORD_MAX, 7'd1}},
            '{CMD_MOD,     '0,       1'b1, '{ST_SHORT,   WORD_MAX, 7'd1}},
            '{CMD_SPARE_7, WORD_MIN, 1'b1, '{ST_OK,      WORD_MAX, 7'd1}},
            '{CMD_PUSH,    WORD_ONE, 1'b1, '{ST_OK,      WORD_ONE, 7'd2}},
            '{CMD_ADD,     '0,       1'b1, '{ST_OK,      WORD_MIN, 7'd1}},
            '{CMD_PUSH,    WORD_NEG, 1'b1, '{ST_OK,      WORD_NEG, 7'd2}},
            '{CMD_DIV,     '0,       1'b1, '{ST_OK,      WORD_MIN, 7'd1}},
            '{CMD_PUSH,    WORD_NEG, 1'b1, '{ST_OK,      WORD_NEG, 7'd2}},
            '{CMD_MOD,     '0,       1'b1, '{ST_OK,      '0,       7'd1}},
            '{CMD_PUSH,    '0,       1'b1, '{ST_OK,      '0,       7'd2}},
            '{CMD_DIV,     WORD_NEG, 1'b1, '{ST_DIVZERO, '0,       7'd2}},
            '{CMD_MOD,     '0,       1'b1, '{ST_DIVZERO, '0,       7'd2}},
            '{CMD_SUB,     '0,       1'b1, '{ST_OK,      '0,       7'd1}},
            '{CMD_PUSH,    -32'sd7,  1'b0, '{ST_OK,      '0,       7'd0}},
            '{CMD_PUSH,    32'sd2,   1'b0, '{ST_OK,      '0,       7'd0}},
            '{CMD_DIV,     '0,       1'b0, '{ST_OK,      '0,       7'd0}},
            '{CMD_PUSH,    32'sd2,   1'b0, '{ST_OK,      '0,       7'd0}},
            '{CMD_MOD,     '0,       1'b0, '{ST_OK,      '0,       7'd0}},
            '{CMD_PUSH,    WORD_MIN, 1'b0, '{ST_OK,      '0,       7'd0}},
            '{CMD_SUB,     '0,       1'b0, '{ST_OK,      '0,       7'd0}},
            '{CMD_PUSH,    WORD_MAX, 1'b0, '{ST_OK,      '0,       7'd0}},
            '{CMD_MUL,     '0,       1'b0, '{ST_OK,      '0,       7'd0}},
            '{CMD_PUSH,    32'sh5a5a_a5a5, 1'b0, '{ST_OK, '0,      7'd0}}
        };
        stack_depth = 0;
        aclk = 1'b0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        build_plan();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // offer each word, with random gaps outside the steady window
        for (int i = 0; i < command_plan_q.size(); i++) begin
            while (!(i >= 150 && i < 260) && $urandom_range(0, 99) < IDLE_PERCENT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= command_plan_q[i].value;
            s_tuser <= command_plan_q[i].cmd;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
        end
        s_tvalid <= 1'b0;

        // drain outstanding results, then let the block settle
        @(posedge aclk);
        while (words_accepted != command_plan_q.size() || pending_results_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random stalls, one long hold-off, and a steady window
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (results_seen == 60) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
                while (results_seen == 60) @(posedge aclk);
            end else if (results_seen >= 300 && results_seen < 420) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Track accepted commands and check each result word in order
    always @(posedge aclk) begin
        sau_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pending_results_q.push_back(command_plan_q[words_accepted].result);
                words_accepted++;
            end
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (pending_results_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected word, expected none, got status %0d top %h count %0d",
                             $time, m_tuser, m_tdata[31:0], m_tdata[38:32]);
                end else begin
                    want = pending_results_q.pop_front();
                    if (m_tuser !== want.status) begin
                        error_count++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, m_tuser);
                    end
                    if (m_tdata[31:0] !== want.top) begin
                        error_count++;
                        $display("%0t: top_value expected %h got %h",
                                 $time, want.top, m_tdata[31:0]);
                    end
                    if (m_tdata[38:32] !== want.count) begin
                        error_count++;
                        $display("%0t: entry_count expected %0d got %0d",
                                 $time, want.count, m_tdata[38:32]);
                    end
                end
            end
        end
    end

    // Hard stop well past the slowest legal run
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/sau_pkg.sv
rtl/sau_cell.sv
rtl/sau_divider.sv
rtl/stack_arithmetic_unit.sv
tb/sv/stack_arithmetic_unit_tb.sv
